/* sv/uts_pkg.sv */
// Types, byte codes and the UTF-8 lead-byte decode for the text sanitizer.
// Used by utf8_text_sanitizer_core; depends on nothing else.
package uts_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] pos_t;
	typedef logic [2:0]  seq_len_t;
	typedef logic [1:0]  seq_cnt_t;

	localparam pos_t  CAPACITY_RESET = 16'd256;

	localparam byte_t CHAR_SPACE = 8'h20;
	localparam byte_t CHAR_QMARK = 8'h3F;
	localparam byte_t CHAR_DEL   = 8'h7F;

	localparam byte_t LEAD2_LO = 8'hC2;
	localparam byte_t LEAD2_HI = 8'hDF;
	localparam byte_t LEAD3_LO = 8'hE0;
	localparam byte_t LEAD3_HI = 8'hEF;
	localparam byte_t LEAD4_LO = 8'hF0;
	localparam byte_t LEAD4_HI = 8'hF4;
	localparam byte_t LEAD_SURR = 8'hED;

	localparam byte_t CONT_MASK  = 8'hC0;
	localparam byte_t CONT_TAG   = 8'h80;
	localparam byte_t CONT_3_MIN = 8'hA0;
	localparam byte_t CONT_4_MIN = 8'h90;

	localparam seq_len_t SEQ_NONE = 3'd0;
	localparam seq_len_t SEQ_TWO  = 3'd2;
	localparam seq_len_t SEQ_THREE = 3'd3;
	localparam seq_len_t SEQ_FOUR = 3'd4;

	// Total sequence length from a lead byte; SEQ_NONE for an invalid lead.
	function automatic seq_len_t lead_length(byte_t b);
		seq_len_t n;
		n = SEQ_NONE;
		if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			n = SEQ_TWO;
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			n = SEQ_THREE;
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			n = SEQ_FOUR;
		end
		return n;
	endfunction

endpackage

/* sv/utf8_text_sanitizer_core.sv */
// UTF-8 validating text sanitizer: input register, one-pass decode, burst register.
// Depends on uts_pkg for types, byte codes and the lead-byte decode.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | in_valid/in_stall  | in_byte, in_last
//  out     | out_valid/out_stall| is_length, out_byte, out_pos, out_length, out_last
//  cfg     | cfg_wr_en          | cfg_wr_data (dest_capacity)
//
// A byte that yields k words holds the burst register until all k are taken, one word per
// cycle while out_stall is low; a byte yielding zero or one word lets the next byte in the
// next cycle unless stalled; each byte passes the input register, then the burst register.
// Reset clears message state and output words; dest_capacity returns to 256.
// out_stall holds the current word and backs up into in_stall once the input register is full.
module utf8_text_sanitizer_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  uts_pkg::pos_t   cfg_wr_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  uts_pkg::byte_t  in_byte,
	input  logic            in_last,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            is_length,
	output uts_pkg::byte_t  out_byte,
	output uts_pkg::pos_t   out_pos,
	output uts_pkg::pos_t   out_length,
	output logic            out_last
);
	import uts_pkg::*;

	pos_t     cap_q;

	logic     valid_s1;
	byte_t    byte_s1;
	logic     last_s1;

	byte_t    buf_q [3];
	seq_len_t exp_q;
	seq_cnt_t col_q;
	pos_t     wp_q;
	pos_t     nse_q;
	logic     halted_q;

	byte_t    byte_s2 [4];
	pos_t     base_s2;
	pos_t     len_s2;
	logic [2:0] ndata_q;
	logic     has_len_q;
	logic [2:0] cnt_q;
	logic [2:0] rd_q;

	logic     in_acc;
	logic     out_acc;
	logic     advance;
	logic     load;

	logic [3:0] ok;
	logic     fits_seq;
	logic     cont;
	seq_len_t lead_n;

	logic     halt_c;
	seq_len_t exp_c;
	seq_cnt_t col_c;
	byte_t    buf_c [3];
	byte_t    dbytes [4];
	logic [2:0] nd;
	logic     fresh;
	pos_t     nse_c;

	// Room checks for four positions and a whole sequence; lead and continuation decode.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ok[k] = ({1'b0, wp_q} + 17'(k + 1)) < {1'b0, cap_q};
		end
		fits_seq = ({1'b0, wp_q} + {14'b0, exp_q}) < {1'b0, cap_q};
		lead_n = lead_length(byte_s1);
		cont = ((byte_s1 & CONT_MASK) == CONT_TAG) &&
			!(col_q == 2'd1 &&
			  ((exp_q == SEQ_THREE && buf_q[0] == LEAD3_LO && byte_s1 < CONT_3_MIN) ||
			   (exp_q == SEQ_THREE && buf_q[0] == LEAD_SURR && byte_s1 >= CONT_3_MIN) ||
			   (exp_q == SEQ_FOUR && buf_q[0] == LEAD4_LO && byte_s1 < CONT_4_MIN) ||
			   (exp_q == SEQ_FOUR && buf_q[0] == LEAD4_HI && byte_s1 >= CONT_4_MIN)));
	end

	// One byte: flush on a broken sequence, finish a sequence, handle a fresh byte,
	// flush a cut-off sequence on the last byte. Data words land at consecutive slots.
	always_comb begin
		halt_c = halted_q;
		exp_c  = exp_q;
		col_c  = col_q;
		buf_c  = buf_q;
		nd     = 3'd0;
		fresh  = 1'b0;
		for (int i = 0; i < 4; i++) begin
			dbytes[i] = CHAR_SPACE;
		end

		if (exp_q == SEQ_NONE) begin
			fresh = 1'b1;
		end else if (!cont) begin
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < col_q) begin
					if (!halt_c && ok[nd[1:0]]) begin
						dbytes[nd[1:0]] = CHAR_QMARK;
						nd = nd + 3'd1;
					end else begin
						halt_c = 1'b1;
					end
				end
			end
			exp_c = SEQ_NONE;
			col_c = 2'd0;
			fresh = 1'b1;
		end else if (({1'b0, col_q} + 3'd1) >= exp_q) begin
			if (fits_seq) begin
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < col_q) begin
						dbytes[i] = buf_q[i];
					end
				end
				dbytes[col_q] = byte_s1;
				nd = exp_q;
			end else begin
				halt_c = 1'b1;
			end
			exp_c = SEQ_NONE;
			col_c = 2'd0;
		end else begin
			buf_c[col_q] = byte_s1;
			col_c = col_q + 2'd1;
		end

		if (fresh) begin
			if (halt_c || !ok[nd[1:0]]) begin
				halt_c = 1'b1;
			end else if (!byte_s1[7]) begin
				dbytes[nd[1:0]] = (byte_s1 < CHAR_SPACE || byte_s1 == CHAR_DEL) ?
					CHAR_SPACE : byte_s1;
				nd = nd + 3'd1;
			end else if (lead_n == SEQ_NONE) begin
				dbytes[nd[1:0]] = CHAR_QMARK;
				nd = nd + 3'd1;
			end else begin
				buf_c[0] = byte_s1;
				exp_c = lead_n;
				col_c = 2'd1;
			end
		end

		// Cut-off sequence at end of message.
		if (last_s1 && exp_c != SEQ_NONE) begin
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < col_c) begin
					if (!halt_c && ok[nd[1:0]]) begin
						dbytes[nd[1:0]] = CHAR_QMARK;
						nd = nd + 3'd1;
					end else begin
						halt_c = 1'b1;
					end
				end
			end
			exp_c = SEQ_NONE;
			col_c = 2'd0;
		end

		nse_c = nse_q;
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < nd && dbytes[i] != CHAR_SPACE) begin
				nse_c = wp_q + 16'(i + 1);
			end
		end
	end

	assign out_valid = (rd_q != cnt_q);
	assign out_acc   = out_valid && !out_stall;
	assign advance   = !out_valid || (out_acc && ((rd_q + 3'd1) == cnt_q));
	assign load      = advance && valid_s1;
	assign in_stall  = valid_s1 && !advance;
	assign in_acc    = in_valid && !in_stall;

	assign is_length  = has_len_q && (rd_q == ndata_q);
	assign out_byte   = is_length ? '0 : byte_s2[rd_q[1:0]];
	assign out_pos    = is_length ? '0 : base_s2 + {13'b0, rd_q};
	assign out_length = is_length ? len_s2 : '0;
	assign out_last   = is_length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// Message state; on the last byte return to the empty message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q    <= SEQ_NONE;
			col_q    <= 2'd0;
			wp_q     <= '0;
			nse_q    <= '0;
			halted_q <= 1'b0;
		end else if (load) begin
			if (last_s1) begin
				exp_q    <= SEQ_NONE;
				col_q    <= 2'd0;
				wp_q     <= '0;
				nse_q    <= '0;
				halted_q <= 1'b0;
			end else begin
				exp_q    <= exp_c;
				col_q    <= col_c;
				wp_q     <= wp_q + {13'b0, nd};
				nse_q    <= nse_c;
				halted_q <= halt_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q   <= buf_c;
			byte_s2 <= dbytes;
			base_s2 <= wp_q;
			len_s2  <= nse_c;
		end
	end

	// Burst register: drain one word per cycle while out_stall is low.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= 3'd0;
			rd_q      <= 3'd0;
			ndata_q   <= 3'd0;
			has_len_q <= 1'b0;
		end else if (load) begin
			cnt_q     <= nd + {2'b0, last_s1};
			rd_q      <= 3'd0;
			ndata_q   <= nd;
			has_len_q <= last_s1;
		end else if (out_acc) begin
			rd_q <= rd_q + 3'd1;
		end
	end

	a_pending_not_halted: assert property (@(posedge clk) disable iff (!arst_n)
		exp_q != SEQ_NONE |-> !halted_q)
		else $error("sequence pending while halted");

	a_collected_range: assert property (@(posedge clk) disable iff (!arst_n)
		exp_q != SEQ_NONE |-> (col_q != 2'd0 && {1'b0, col_q} < exp_q))
		else $error("collected count out of range for pending sequence");

	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rd_q < cnt_q && cnt_q <= 3'd5))
		else $error("burst read index beyond burst");

	a_length_closes_burst: assert property (@(posedge clk) disable iff (!arst_n)
		is_length && out_valid |-> (rd_q + 3'd1) == cnt_q)
		else $error("length word is not the final word of its burst");

endmodule
